### rtl/shell_sort_ciura_records_assert.svh
// assertion macros used by the checker file
`ifndef SHELL_SORT_CIURA_RECORDS_ASSERT_SVH
`define SHELL_SORT_CIURA_RECORDS_ASSERT_SVH

// implication checked every cycle outside reset
`define SSC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// implication checked on the following cycle
`define SSC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/ssc_pkg.sv
// ----------------------------------------------------------------------------
// ssc_pkg
// types, constants and compare function for the record shell sorter
// ----------------------------------------------------------------------------
package ssc_pkg;

  localparam int MaxRecords = 64;
  localparam int AddrW      = $clog2(MaxRecords);
  localparam int CntW       = $clog2(MaxRecords + 1);
  localparam int GapCount   = 9;
  localparam int GapIdxW    = 4;

  typedef struct packed {
    logic [23:0] student_id;
    logic [7:0]  gender_code;
    logic [6:0]  korean_score;
    logic [6:0]  english_score;
    logic [6:0]  math_score;
    logic [5:0]  record_tag;
  } rec_t;

  typedef enum logic [2:0] {
    KEY_ID_ASC    = 3'd0,
    KEY_ID_DESC   = 3'd1,
    KEY_GEN_ASC   = 3'd2,
    KEY_GEN_DESC  = 3'd3,
    KEY_TOT_ASC   = 3'd4,
    KEY_TOT_DESC  = 3'd5
  } key_mode_e;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_GAP,
    ST_OUTER,
    ST_HOLD,
    ST_RDCMP,
    ST_CMP,
    ST_PLACE,
    ST_OUT_RD,
    ST_OUT_WAIT,
    ST_OUT
  } state_e;

  function automatic logic [10:0] gap_of(input logic [GapIdxW-1:0] idx);
    case (idx)
      4'd0:    gap_of = 11'd1750;
      4'd1:    gap_of = 11'd701;
      4'd2:    gap_of = 11'd301;
      4'd3:    gap_of = 11'd132;
      4'd4:    gap_of = 11'd57;
      4'd5:    gap_of = 11'd23;
      4'd6:    gap_of = 11'd10;
      4'd7:    gap_of = 11'd4;
      default: gap_of = 11'd1;
    endcase
  endfunction

  // true when a sorts strictly after b
  function automatic logic after(input rec_t a, input rec_t b, input logic [2:0] mode);
    logic [8:0] ta;
    logic [8:0] tb;
    logic       gt;
    logic       lt;
    ta = 9'(a.korean_score) + 9'(a.english_score) + 9'(a.math_score);
    tb = 9'(b.korean_score) + 9'(b.english_score) + 9'(b.math_score);
    gt = 1'b0;
    lt = 1'b0;
    case (mode)
      KEY_ID_DESC:  after = b.student_id > a.student_id;
      KEY_GEN_ASC:  after = a.gender_code > b.gender_code;
      KEY_GEN_DESC: after = b.gender_code > a.gender_code;
      KEY_TOT_ASC, KEY_TOT_DESC: begin
        if (ta != tb) begin
          gt = ta > tb; lt = ta < tb;
        end else if (a.korean_score != b.korean_score) begin
          gt = a.korean_score > b.korean_score; lt = !gt;
        end else if (a.english_score != b.english_score) begin
          gt = a.english_score > b.english_score; lt = !gt;
        end else if (a.math_score != b.math_score) begin
          gt = a.math_score > b.math_score; lt = !gt;
        end
        after = (mode == KEY_TOT_DESC) ? lt : gt;
      end
      default:      after = a.student_id > b.student_id;
    endcase
  endfunction

endpackage

### rtl/ssc_rec_if.sv
// ----------------------------------------------------------------------------
// ssc_rec_if
// valid/ready record channel with source and sink views
// ----------------------------------------------------------------------------
interface ssc_rec_if;
  logic        valid;
  logic        ready;
  logic [23:0] student_id;
  logic [7:0]  gender_code;
  logic [6:0]  korean_score;
  logic [6:0]  english_score;
  logic [6:0]  math_score;
  logic [5:0]  record_tag;
  logic        last;

  modport source (output valid, student_id, gender_code, korean_score, english_score,
                  math_score, record_tag, last, input ready);
  modport sink   (input valid, student_id, gender_code, korean_score, english_score,
                  math_score, record_tag, last, output ready);
endinterface

### rtl/ssc_ram.sv
// ----------------------------------------------------------------------------
// ssc_ram
// single port record store, registered read
// ----------------------------------------------------------------------------
module ssc_ram #(
  parameter int Depth = 64,
  parameter int Width = 59
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end
endmodule

### rtl/shell_sort_ciura_records.sv
// ----------------------------------------------------------------------------
// shell_sort_ciura_records
// loads student records, shell sorts them with ciura gaps, streams them out
// ----------------------------------------------------------------------------
// channel   dir  handshake         payload
// in_rec    in   valid/ready       record + last
// out_rec   out  valid/ready       record + last
// cfg       in   sort_key_mode_we  3-bit key mode
//
// one record per cycle is loaded; the last record starts the sort.
// each insertion step is a read then compare/write on the single ram port:
// a compare passes ST_RDCMP and ST_CMP, an outer position ST_OUTER, ST_HOLD and ST_PLACE,
// a gap tested ST_GAP; each output record ST_OUT_RD, ST_OUT_WAIT and ST_OUT until taken.
// input ready is low from the last record until the final output is taken.
// reset clears control state; store contents are undefined until loaded.
module shell_sort_ciura_records (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       sort_key_mode_we_i,
  input  logic [2:0] sort_key_mode_i,
  ssc_rec_if.sink    in_rec,
  ssc_rec_if.source  out_rec
);
  import ssc_pkg::*;

  state_e          state_q, state_d;
  logic [2:0]      mode_q;
  logic [CntW-1:0] count_q, count_d;
  logic [GapIdxW-1:0] gidx_q, gidx_d;
  logic [CntW-1:0] outer_q, outer_d;
  logic [CntW-1:0] inner_q, inner_d;
  rec_t            held_q, held_d;
  rec_t            prev_q, prev_d;
  rec_t            rdata;
  logic            we;
  logic [AddrW-1:0] addr;
  rec_t            wdata;
  logic [10:0]     gap;
  logic [CntW-1:0] gap_n;
  logic            in_take;

  assign gap     = gap_of(gidx_q);
  assign gap_n   = CntW'(gap);
  assign in_take = in_rec.valid && in_rec.ready;

  ssc_ram #(.Depth(MaxRecords), .Width($bits(rec_t))) u_ram (
    .clk_i,
    .we_i(we),
    .addr_i(addr),
    .wdata_i(wdata),
    .rdata_o(rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      mode_q  <= 3'd0;
      count_q <= '0;
      gidx_q  <= '0;
      outer_q <= '0;
      inner_q <= '0;
      held_q  <= '0;
    end else begin
      state_q <= state_d;
      if (sort_key_mode_we_i) begin
        mode_q <= sort_key_mode_i;
      end
      count_q <= count_d;
      gidx_q  <= gidx_d;
      outer_q <= outer_d;
      inner_q <= inner_d;
      held_q  <= held_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prev_q <= prev_d;
  end

  // next state and counters
  always_comb begin
    state_d = state_q;
    count_d = count_q;
    gidx_d  = gidx_q;
    outer_d = outer_q;
    inner_d = inner_q;
    held_d  = held_q;
    prev_d  = prev_q;
    case (state_q)
      ST_LOAD: begin
        if (in_take) begin
          if (count_q < CntW'(MaxRecords)) count_d = count_q + 1'b1;
          if (in_rec.last) begin
            gidx_d  = '0;
            state_d = ST_GAP;
          end
        end
      end
      ST_GAP: begin
        if (gidx_q == GapIdxW'(GapCount)) begin
          outer_d = '0;
          state_d = (count_q == '0) ? ST_LOAD : ST_OUT_RD;
        end else if (gap < 11'(count_q)) begin
          outer_d = gap_n;
          state_d = ST_OUTER;
        end else begin
          gidx_d = gidx_q + 1'b1;
        end
      end
      ST_OUTER: begin
        if (outer_q >= count_q) begin
          gidx_d  = gidx_q + 1'b1;
          state_d = ST_GAP;
        end else begin
          inner_d = outer_q;
          state_d = ST_HOLD;
        end
      end
      ST_HOLD: begin
        held_d  = rdata;
        state_d = (inner_q >= gap_n) ? ST_RDCMP : ST_PLACE;
      end
      ST_RDCMP: state_d = ST_CMP;
      ST_CMP: begin
        if (after(rdata, held_q, mode_q)) begin
          inner_d = inner_q - gap_n;
          state_d = (inner_q - gap_n >= gap_n) ? ST_RDCMP : ST_PLACE;
        end else begin
          state_d = ST_PLACE;
        end
      end
      ST_PLACE: begin
        outer_d = outer_q + 1'b1;
        state_d = ST_OUTER;
      end
      ST_OUT_RD:   state_d = ST_OUT_WAIT;
      ST_OUT_WAIT: begin
        prev_d  = rdata;
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (out_rec.ready) begin
          if (outer_q + 1'b1 == count_q) begin
            count_d = '0;
            gidx_d  = '0;
            outer_d = '0;
            inner_d = '0;
            state_d = ST_LOAD;
          end else begin
            outer_d = outer_q + 1'b1;
            state_d = ST_OUT_RD;
          end
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

  // memory port and handshake outputs
  always_comb begin
    we    = 1'b0;
    addr  = '0;
    wdata = rdata;
    in_rec.ready  = 1'b0;
    out_rec.valid = 1'b0;
    case (state_q)
      ST_LOAD: begin
        in_rec.ready = 1'b1;
        addr  = count_q[AddrW-1:0];
        wdata = '{in_rec.student_id, in_rec.gender_code, in_rec.korean_score,
                  in_rec.english_score, in_rec.math_score, in_rec.record_tag};
        we    = in_take && (count_q < CntW'(MaxRecords));
      end
      ST_OUTER:  addr = outer_q[AddrW-1:0];
      ST_RDCMP:  addr = AddrW'(inner_q - gap_n);
      ST_CMP: begin
        // shift the record that sorts after the held one up one gap
        addr  = inner_q[AddrW-1:0];
        wdata = rdata;
        we    = after(rdata, held_q, mode_q);
      end
      ST_PLACE: begin
        addr  = inner_q[AddrW-1:0];
        wdata = held_q;
        we    = 1'b1;
      end
      ST_OUT_RD: addr = outer_q[AddrW-1:0];
      ST_OUT:    out_rec.valid = 1'b1;
      default: ;
    endcase
  end

  assign out_rec.student_id    = prev_q.student_id;
  assign out_rec.gender_code   = prev_q.gender_code;
  assign out_rec.korean_score  = prev_q.korean_score;
  assign out_rec.english_score = prev_q.english_score;
  assign out_rec.math_score    = prev_q.math_score;
  assign out_rec.record_tag    = prev_q.record_tag;
  assign out_rec.last          = (outer_q + 1'b1 == count_q);

endmodule

### rtl/ssc_checker.sv
// ----------------------------------------------------------------------------
// ssc_checker
// port level checks for the record shell sorter
// ----------------------------------------------------------------------------
`include "shell_sort_ciura_records_assert.svh"

module ssc_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid,
  input logic in_ready,
  input logic in_last,
  input logic out_valid,
  input logic out_ready,
  input logic out_last
);
  `SSC_ASSERT_IMP(a_no_overlap, clk_i, rst_ni, out_valid, !in_ready, "input open while output")
  `SSC_ASSERT_NEXT(a_last_closes, clk_i, rst_ni, in_valid && in_ready && in_last, !in_ready, "input open after last")
  `SSC_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid && !out_ready, out_valid && $stable(out_last), "output dropped")
  `SSC_ASSERT_NEXT(a_end_reopen, clk_i, rst_ni, out_valid && out_ready && out_last, !out_valid, "output after last")
endmodule

bind shell_sort_ciura_records ssc_checker u_ssc_checker (
  .clk_i(clk_i),
  .rst_ni(rst_ni),
  .in_valid(in_rec.valid),
  .in_ready(in_rec.ready),
  .in_last(in_rec.last),
  .out_valid(out_rec.valid),
  .out_ready(out_rec.ready),
  .out_last(out_rec.last)
);

### test/ssc_test_if.sv
// ----------------------------------------------------------------------------
// ssc_test_if
// testbench-side copy of the record channel is not needed; the rtl interface
// ssc_rec_if is used directly for both channels
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package ssc_test_pkg;
  localparam int RunItems = 150;
endpackage

### test/shell_sort_ciura_records_test.sv
// ----------------------------------------------------------------------------
// shell_sort_ciura_records_test
// loads random record sets, predicts the sorted order for each key mode and
// checks every streamed record and its last flag
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module shell_sort_ciura_records_test;
  import ssc_pkg::*;

  typedef struct packed {
    rec_t rec;
    logic last;
  } beat_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic sort_key_mode_we_i = 1'b0;
  logic [2:0] sort_key_mode_i = '0;

  ssc_rec_if in_rec ();
  ssc_rec_if out_rec ();

  shell_sort_ciura_records i_dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .sort_key_mode_we_i(sort_key_mode_we_i), .sort_key_mode_i(sort_key_mode_i),
    .in_rec(in_rec.sink), .out_rec(out_rec.source)
  );

  always #1 clk_i = ~clk_i;

  beat_t pending_q[$];
  beat_t sorted_q[$];
  rec_t  set_buf[$];
  logic [2:0] key_mode = KEY_ID_ASC;
  int mismatches = 0;
  int idle_cycles = 0;
  int hold_cycles = 0;
  bit calm = 1'b0;
  bit hold_sink = 1'b0;
  bit sender_pause = 1'b0;

  // strict "a sorts after b", own reading of the key modes
  function automatic bit sorts_after(rec_t a, rec_t b, logic [2:0] mode);
    int sa, sb, r;
    sa = a.korean_score + a.english_score + a.math_score;
    sb = b.korean_score + b.english_score + b.math_score;
    case (mode)
      KEY_ID_DESC:  return b.student_id > a.student_id;
      KEY_GEN_ASC:  return a.gender_code > b.gender_code;
      KEY_GEN_DESC: return b.gender_code > a.gender_code;
      KEY_TOT_ASC, KEY_TOT_DESC: begin
        r = (sa > sb) - (sa < sb);
        if (r == 0)
          r = (a.korean_score > b.korean_score) - (a.korean_score < b.korean_score);
        if (r == 0)
          r = (a.english_score > b.english_score) - (a.english_score < b.english_score);
        if (r == 0)
          r = (a.math_score > b.math_score) - (a.math_score < b.math_score);
        return (mode == KEY_TOT_DESC) ? (r < 0) : (r > 0);
      end
      default:      return a.student_id > b.student_id;
    endcase
  endfunction

  // shell sort of the loaded set and queueing of the streamed order
  task automatic predict_sorted_set();
    int gaps[9] = '{1750, 701, 301, 132, 57, 23, 10, 4, 1};
    rec_t arr[$];
    rec_t held;
    int n, j;
    beat_t b;
    arr = set_buf;
    n = arr.size();
    foreach (gaps[g]) begin
      if (gaps[g] >= n) continue;
      for (int i = gaps[g]; i < n; i++) begin
        held = arr[i];
        j = i;
        while (j >= gaps[g] && sorts_after(arr[j-gaps[g]], held, key_mode)) begin
          arr[j] = arr[j-gaps[g]];
          j -= gaps[g];
        end
        arr[j] = held;
      end
    end
    for (int k = 0; k < n; k++) begin
      b.rec = arr[k];
      b.last = (k == n - 1);
      sorted_q.push_back(b);
    end
    set_buf.delete();
  endtask

  function automatic rec_t random_record(bit corner);
    rec_t r;
    r.student_id = corner ? ($urandom_range(1) ? 24'hFFFFFF : 24'h0) : 24'($urandom);
    r.gender_code = ($urandom_range(3) == 0) ? 8'($urandom) :
                    ($urandom_range(1) ? 8'h46 : 8'h4D);
    r.korean_score = ($urandom_range(9) == 0) ? 7'($urandom) : 7'($urandom_range(100));
    r.english_score = ($urandom_range(9) == 0) ? 7'($urandom) : 7'($urandom_range(100));
    r.math_score = ($urandom_range(9) == 0) ? 7'($urandom) : 7'($urandom_range(100));
    r.record_tag = 6'($urandom);
    // narrow ranges make ties likely
    if (!corner && $urandom_range(2) == 0) begin
      r.student_id = 24'($urandom_range(7));
      r.korean_score = 7'($urandom_range(98, 100));
      r.english_score = 7'($urandom_range(98, 100));
      r.math_score = 7'($urandom_range(98, 100));
    end
    return r;
  endfunction

  task automatic add_set(int n, bit corner);
    beat_t b;
    for (int k = 0; k < n; k++) begin
      b.rec = random_record(corner);
      b.last = (k == n - 1);
      pending_q.push_back(b);
    end
  endtask

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_rec.valid <= 1'b0;
      {in_rec.student_id, in_rec.gender_code, in_rec.korean_score,
       in_rec.english_score, in_rec.math_score, in_rec.record_tag} <= '0;
      in_rec.last <= 1'b0;
    end else begin
      if (in_rec.valid && in_rec.ready) begin
        // store-full records are dropped by the block
        if (set_buf.size() < MaxRecords) set_buf.push_back(in_rec.student_id === 'x ?
            '0 : {in_rec.student_id, in_rec.gender_code, in_rec.korean_score,
                  in_rec.english_score, in_rec.math_score, in_rec.record_tag});
        if (in_rec.last) predict_sorted_set();
      end
      if ((!in_rec.valid || in_rec.ready) && !sender_pause) begin
        if (pending_q.size() > 0 && (calm || $urandom_range(99) >= 19)) begin
          {in_rec.student_id, in_rec.gender_code, in_rec.korean_score,
           in_rec.english_score, in_rec.math_score, in_rec.record_tag} <= pending_q[0].rec;
          in_rec.last <= pending_q[0].last;
          in_rec.valid <= 1'b1;
          void'(pending_q.pop_front());
        end else begin
          in_rec.valid <= 1'b0;
        end
      end else if (sender_pause && in_rec.ready) begin
        in_rec.valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    beat_t got, want;
    if (!rst_ni) begin
      out_rec.ready <= 1'b0;
    end else begin
      if (out_rec.valid && out_rec.ready) begin
        got.rec = {out_rec.student_id, out_rec.gender_code, out_rec.korean_score,
                   out_rec.english_score, out_rec.math_score, out_rec.record_tag};
        got.last = out_rec.last;
        if (sorted_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected transaction %h", got);
        end else begin
          want = sorted_q.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"mismatch: expected id %h gen %h k %0d e %0d m %0d tag %0d last %b,",
                        " got id %h gen %h k %0d e %0d m %0d tag %0d last %b"},
                want.rec.student_id, want.rec.gender_code, want.rec.korean_score,
                want.rec.english_score, want.rec.math_score, want.rec.record_tag,
                want.last,
                got.rec.student_id, got.rec.gender_code, got.rec.korean_score,
                got.rec.english_score, got.rec.math_score, got.rec.record_tag,
                got.last);
          end
        end
      end
      out_rec.ready <= !hold_sink && (calm || $urandom_range(99) >= 19);
    end
  end

  // length of the current receiver hold
  always @(posedge clk_i) begin
    if (hold_sink) hold_cycles <= hold_cycles + 1;
    else hold_cycles <= 0;
  end

  // watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if ((in_rec.valid && in_rec.ready) || (out_rec.valid && out_rec.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 60000) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic wait_drained();
    while (pending_q.size() > 0 || in_rec.valid || sorted_q.size() > 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic set_key_mode(logic [2:0] mode);
    sort_key_mode_i <= mode;
    sort_key_mode_we_i <= 1'b1;
    @(posedge clk_i);
    sort_key_mode_we_i <= 1'b0;
    key_mode = mode;
  endtask

  initial begin
    int sent;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: single record and two records with extreme ids, then three records with each mode
    add_set(1, 1'b1);
    add_set(2, 1'b1);
    wait_drained();
    for (int m = 0; m < 8; m++) begin
      set_key_mode(m[2:0]);
      add_set(3, 1'b0);
      wait_drained();
    end

    // long receiver hold: the output stalls and the block holds its input ready low
    set_key_mode(KEY_TOT_DESC);
    hold_sink = 1'b1;
    add_set(20, 1'b0);
    add_set(5, 1'b0);
    wait (hold_cycles >= 1500);
    hold_sink = 1'b0;
    wait_drained();

    // store full: extra records are dropped
    set_key_mode(KEY_ID_ASC);
    add_set(MaxRecords + 3, 1'b0);
    wait_drained();

    sent = 0;
    while (sent < ssc_test_pkg::RunItems) begin
      int n;
      bit do_pause;
      n = ($urandom_range(7) == 0) ? $urandom_range(30, 64) : $urandom_range(1, 12);
      do_pause = (sent == 0) || ($urandom_range(5) == 0);
      set_key_mode(3'($urandom_range(5)));
      calm = ($urandom_range(4) == 0);
      add_set(n, 1'b0);
      sent += n;
      // sender pause until every result is back
      if (do_pause) begin
        add_set(3, 1'b0);
        sent += 3;
        while (sorted_q.size() == 0) @(posedge clk_i);
        sender_pause = 1'b1;
        while (sorted_q.size() > 0) @(posedge clk_i);
        sender_pause = 1'b0;
      end
      wait_drained();
    end
    set_key_mode(KEY_GEN_DESC);
    add_set(64, 1'b0);
    wait_drained();
    set_key_mode(3'd7);
    add_set(9, 1'b0);
    wait_drained();
    repeat (50) @(posedge clk_i);

    if (mismatches == 0 && sorted_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
